[sv/rpt_pkg.sv]
package rpt_pkg;

  localparam int PRESS_W       = 13;
  localparam int TEMP_W        = 16;
  localparam int BP_TEMP_W     = 8;
  localparam int TABLE_ROWS    = 52;
  localparam int TABLE_ENTRIES = 52;
  localparam int N_ROWS        = (TABLE_ENTRIES > TABLE_ROWS) ? TABLE_ROWS :
                                 ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int IDX_W         = $clog2(TABLE_ROWS);
  localparam int SPAN_W        = 8;
  localparam int DP_W          = SPAN_W;
  localparam int FRAC_W        = 9;
  localparam int DIV_STAGES    = 3;
  localparam int DIV_STEPS     = FRAC_W / DIV_STAGES;

  localparam logic signed [TEMP_W-1:0] SENTINEL_Q8 = -16'sd25600;

  localparam logic [PRESS_W-1:0] BP_PRESS [TABLE_ROWS] = '{
    13'd172,  13'd195,  13'd220,  13'd247,  13'd275,  13'd304,  13'd336,  13'd369,
    13'd405,  13'd442,  13'd481,  13'd523,  13'd567,  13'd613,  13'd661,  13'd712,
    13'd765,  13'd821,  13'd880,  13'd941,  13'd1006, 13'd1073, 13'd1143, 13'd1217,
    13'd1293, 13'd1373, 13'd1457, 13'd1544, 13'd1634, 13'd1728, 13'd1826, 13'd1928,
    13'd2034, 13'd2144, 13'd2258, 13'd2377, 13'd2500, 13'd2628, 13'd2760, 13'd2898,
    13'd3040, 13'd3187, 13'd3340, 13'd3498, 13'd3662, 13'd3832, 13'd4008, 13'd4190,
    13'd4378, 13'd4573, 13'd4776, 13'd4985
  };

  localparam logic signed [BP_TEMP_W-1:0] BP_TEMP [TABLE_ROWS] = '{
    -8'sd30, -8'sd28, -8'sd26, -8'sd24, -8'sd22, -8'sd20, -8'sd18, -8'sd16,
    -8'sd14, -8'sd12, -8'sd10, -8'sd8,  -8'sd6,  -8'sd4,  -8'sd2,  8'sd0,
    8'sd2,   8'sd4,   8'sd6,   8'sd8,   8'sd10,  8'sd12,  8'sd14,  8'sd16,
    8'sd18,  8'sd20,  8'sd22,  8'sd24,  8'sd26,  8'sd28,  8'sd30,  8'sd32,
    8'sd34,  8'sd36,  8'sd38,  8'sd40,  8'sd42,  8'sd44,  8'sd46,  8'sd48,
    8'sd50,  8'sd52,  8'sd54,  8'sd56,  8'sd58,  8'sd60,  8'sd62,  8'sd64,
    8'sd66,  8'sd68,  8'sd70,  8'sd72
  };

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [PRESS_W-1:0] pressure;
  } rpt_idx_t;

  typedef struct packed {
    logic [DP_W-1:0]                  dp;
    logic [SPAN_W-1:0]                span;
    logic signed [BP_TEMP_W-1:0]      base;
    logic                             in_range;
  } rpt_seg_t;

  typedef struct packed {
    logic [FRAC_W-1:0]                frac;
    logic signed [BP_TEMP_W-1:0]      base;
    logic                             in_range;
  } rpt_quo_t;

  typedef struct packed {
    logic             bit_q;
    logic [DP_W-1:0]  rem;
  } rpt_step_t;

  // one restoring division step, remainder stays below the span
  function automatic rpt_step_t rpt_div_step(input logic [DP_W-1:0] rem,
                                             input logic [SPAN_W-1:0] span);
    logic [DP_W:0] rem2;
    logic [DP_W:0] diff;
    rpt_step_t     res;
    rem2 = {rem, 1'b0};
    diff = rem2 - {1'b0, span};
    if (rem2 >= {1'b0, span}) begin
      res.bit_q = 1'b1;
      res.rem   = diff[DP_W-1:0];
    end else begin
      res.bit_q = 1'b0;
      res.rem   = rem2[DP_W-1:0];
    end
    return res;
  endfunction

endpackage

[sv/rpt_search.sv]
module rpt_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rpt_pkg::PRESS_W-1:0]  in_pressure,
  output logic                         out_valid,
  input  logic                         out_ready,
  output rpt_pkg::rpt_idx_t            out_data
);
  import rpt_pkg::*;

  logic                va_r;
  logic                vb_r;
  logic                rdy_a;
  logic                rdy_b;
  logic [N_ROWS-1:0]   thr_r;
  logic [N_ROWS-1:0]   thr_nxt;
  logic [PRESS_W-1:0]  press_a_r;
  rpt_idx_t            idx_r;
  rpt_idx_t            idx_nxt;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // breakpoint compares, a thermometer code since the table ascends
  always_comb begin
    for (int k = 0; k < N_ROWS; k++) begin
      thr_nxt[k] = (in_pressure >= BP_PRESS[k]);
    end
  end

  always_comb begin
    idx_nxt          = '0;
    idx_nxt.pressure = press_a_r;
    idx_nxt.in_range = thr_r[0] && !thr_r[N_ROWS-1];
    for (int k = 0; k < N_ROWS - 1; k++) begin
      if (thr_r[k] && !thr_r[k+1]) begin
        idx_nxt.idx = idx_nxt.idx | IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      thr_r     <= thr_nxt;
      press_a_r <= in_pressure;
    end
    if (rdy_b && va_r) begin
      idx_r <= idx_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_data  = idx_r;

endmodule

[sv/rpt_segment.sv]
module rpt_segment (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpt_pkg::rpt_idx_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpt_pkg::rpt_seg_t  out_data
);
  import rpt_pkg::*;

  logic               v_r;
  rpt_seg_t           seg_r;
  rpt_seg_t           seg_nxt;
  logic [PRESS_W-1:0] lo;
  logic [PRESS_W-1:0] hi;
  logic [PRESS_W-1:0] dp_full;
  logic [PRESS_W-1:0] span_full;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    lo               = BP_PRESS[in_data.idx];
    hi               = BP_PRESS[in_data.idx + IDX_W'(1)];
    dp_full          = in_data.pressure - lo;
    span_full        = hi - lo;
    seg_nxt.dp       = dp_full[DP_W-1:0];
    seg_nxt.span     = span_full[SPAN_W-1:0];
    seg_nxt.base     = BP_TEMP[in_data.idx];
    seg_nxt.in_range = in_data.in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      seg_r <= seg_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = seg_r;

endmodule

[sv/rpt_div.sv]
module rpt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpt_pkg::rpt_seg_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpt_pkg::rpt_quo_t  out_data
);
  import rpt_pkg::*;

  logic                         v_r    [DIV_STAGES];
  logic [DIV_STAGES-1:0]        rdy;
  logic [DIV_STAGES-1:0]        v_in;
  logic [DP_W-1:0]              rem_r  [DIV_STAGES];
  logic [SPAN_W-1:0]            span_r [DIV_STAGES];
  logic [FRAC_W-1:0]            frac_r [DIV_STAGES];
  logic signed [BP_TEMP_W-1:0]  base_r [DIV_STAGES];
  logic                         rng_r  [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DP_W-1:0]             rem_in;
    logic [SPAN_W-1:0]           span_in;
    logic [FRAC_W-1:0]           frac_in;
    logic signed [BP_TEMP_W-1:0] base_in;
    logic                        rng_in;
    logic                        rdy_down;
    logic [DP_W-1:0]             rem_nxt;
    logic [FRAC_W-1:0]           frac_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = in_data.dp;
      assign span_in = in_data.span;
      assign frac_in = '0;
      assign base_in = in_data.base;
      assign rng_in  = in_data.in_range;
      assign v_in[s] = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign span_in = span_r[s-1];
      assign frac_in = frac_r[s-1];
      assign base_in = base_r[s-1];
      assign rng_in  = rng_r[s-1];
      assign v_in[s] = v_r[s-1];
    end

    if (s == DIV_STAGES - 1) begin : g_last
      assign rdy_down = out_ready;
    end else begin : g_mid
      assign rdy_down = rdy[s+1];
    end

    assign rdy[s] = !v_r[s] || rdy_down;

    always_comb begin
      rpt_step_t st;
      rem_nxt  = rem_in;
      frac_nxt = frac_in;
      for (int j = 0; j < DIV_STEPS; j++) begin
        st       = rpt_div_step(rem_nxt, span_in);
        rem_nxt  = st.rem;
        frac_nxt = {frac_nxt[FRAC_W-2:0], st.bit_q};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s] && v_in[s]) begin
        rem_r[s]  <= rem_nxt;
        span_r[s] <= span_in;
        frac_r[s] <= frac_nxt;
        base_r[s] <= base_in;
        rng_r[s]  <= rng_in;
      end
    end
  end

  assign in_ready          = rdy[0];
  assign out_valid         = v_r[DIV_STAGES-1];
  assign out_data.frac     = frac_r[DIV_STAGES-1];
  assign out_data.base     = base_r[DIV_STAGES-1];
  assign out_data.in_range = rng_r[DIV_STAGES-1];

endmodule

[sv/refrigerant_pressure_to_temp_unit.sv]
// refrigerant saturation temperature from pressure, piecewise linear table
//
// input channel: in_valid / in_stall with in_pressure (13 bit unsigned)
// result channel: out_valid / out_stall with out_temperature (signed, 1/256 C)
// and out_in_range; an item moves at an edge where valid is high and stall low
//
// every input item gives exactly one result item, in order
// from acceptance to out_valid an item passes the stages breakpoint compare, index
// encode, segment fetch, three radix-2 divider stages of 3 bits each, and output
// throughput: one item per cycle while out_stall is low; each stage holds one
// item and moves on when the stage after it is empty or moving, so bubbles close up
// out of table span (below the first or at/above the last breakpoint) gives
// -100 C with out_in_range low
// reset (rst_n low, synchronous) empties all stages; out_valid drops at once
// while out_stall is high the result holds and the stages behind it keep
// filling; in_stall rises only when every stage holds an item
module refrigerant_pressure_to_temp_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rpt_pkg::PRESS_W-1:0]         in_pressure,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rpt_pkg::TEMP_W-1:0]   out_temperature,
  output logic                                out_in_range
);
  import rpt_pkg::*;

  logic                       srch_valid;
  logic                       srch_ready;
  logic                       in_ready;
  rpt_idx_t                   srch_data;
  logic                       seg_valid;
  logic                       seg_ready;
  rpt_seg_t                   seg_data;
  logic                       div_valid;
  logic                       div_ready;
  rpt_quo_t                   div_data;
  logic                       out_valid_r;
  logic signed [TEMP_W-1:0]   temp_r;
  logic signed [TEMP_W-1:0]   temp_nxt;
  logic                       rng_r;

  rpt_search u_search (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_pressure (in_pressure),
    .out_valid   (srch_valid),
    .out_ready   (srch_ready),
    .out_data    (srch_data)
  );

  rpt_segment u_segment (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (srch_valid),
    .in_ready  (srch_ready),
    .in_data   (srch_data),
    .out_valid (seg_valid),
    .out_ready (seg_ready),
    .out_data  (seg_data)
  );

  rpt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_valid),
    .in_ready  (seg_ready),
    .in_data   (seg_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  assign div_ready = !out_valid_r || !out_stall;

  always_comb begin
    if (div_data.in_range) begin
      temp_nxt = {div_data.base, 8'h00} + TEMP_W'(div_data.frac);
    end else begin
      temp_nxt = SENTINEL_Q8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready && div_valid) begin
      temp_r <= temp_nxt;
      rng_r  <= div_data.in_range;
    end
  end

  assign in_stall        = !in_ready;
  assign out_valid       = out_valid_r;
  assign out_temperature = temp_r;
  assign out_in_range    = rng_r;

endmodule

[sv/rpt_checker.sv]
module rpt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [rpt_pkg::TEMP_W-1:0]   out_temperature,
  input logic                                out_in_range
);
  import rpt_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature)
                               && $stable(out_in_range))
    else $error("stalled result item changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_temperature == SENTINEL_Q8)
    else $error("out of range item without sentinel");

  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |-> out_temperature >= -16'sd7680
                                  && out_temperature < -16'sd7680 + 16'sd26112)
    else $error("in range temperature outside table span");

  // an empty output stage means every stage can move
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind refrigerant_pressure_to_temp_unit rpt_checker u_rpt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_temperature (out_temperature),
  .out_in_range    (out_in_range)
);

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpt_pkg::PRESS_W;
  import rpt_pkg::TEMP_W;

  localparam int N_BP       = 52;
  localparam int SENTINEL   = -25600;
  localparam int RAND_ITEMS = 1900;
  localparam int LONG_HOLD  = 80;
  localparam int LIMIT      = 600000;
  localparam int DRAIN      = 20;

  localparam int PRESS_TAB [N_BP] = '{
    172, 195, 220, 247, 275, 304, 336, 369, 405, 442,
    481, 523, 567, 613, 661, 712, 765, 821, 880, 941,
    1006, 1073, 1143, 1217, 1293, 1373, 1457, 1544, 1634, 1728,
    1826, 1928, 2034, 2144, 2258, 2377, 2500, 2628, 2760, 2898,
    3040, 3187, 3340, 3498, 3662, 3832, 4008, 4190, 4378, 4573,
    4776, 4985
  };

  localparam int TEMP_TAB [N_BP] = '{
    -30, -28, -26, -24, -22, -20, -18, -16, -14, -12,
    -10, -8, -6, -4, -2, 0, 2, 4, 6, 8,
    10, 12, 14, 16, 18, 20, 22, 24, 26, 28,
    30, 32, 34, 36, 38, 40, 42, 44, 46, 48,
    50, 52, 54, 56, 58, 60, 62, 64, 66, 68,
    70, 72
  };

  class temp_scoreboard;
    typedef struct {
      logic signed [TEMP_W-1:0] temperature;
      logic                     in_range;
    } reading_t;

    reading_t expected_q[$];
    int       errors;
    int       checked;
    int       out_of_span;

    function new();
      errors      = 0;
      checked     = 0;
      out_of_span = 0;
    endfunction

    // linear interpolation between breakpoints, floor toward minus infinity
    function void note_pressure(logic [PRESS_W-1:0] p);
      reading_t r;
      int       pv;
      int       num;
      int       span;
      int       quot;
      pv            = int'(p);
      r.temperature = TEMP_W'(SENTINEL);
      r.in_range    = 1'b0;
      if (pv >= PRESS_TAB[0]) begin
        for (int i = 0; i < N_BP - 1; i++) begin
          if (pv >= PRESS_TAB[i] && pv < PRESS_TAB[i+1]) begin
            span = PRESS_TAB[i+1] - PRESS_TAB[i];
            num  = (TEMP_TAB[i+1] - TEMP_TAB[i]) * 256 * (pv - PRESS_TAB[i]);
            quot = (num >= 0) ? num / span : -((-num + span - 1) / span);
            r.temperature = TEMP_W'(TEMP_TAB[i] * 256 + quot);
            r.in_range    = 1'b1;
            break;
          end
        end
      end
      if (!r.in_range) out_of_span++;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [TEMP_W-1:0] t, logic r);
      reading_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: temperature %0d in_range %0b", t, r);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (t !== e.temperature) begin
        $error("temperature: expected %0d, got %0d", e.temperature, t);
        errors++;
      end
      if (r !== e.in_range) begin
        $error("in_range: expected %0b, got %0b", e.in_range, r);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [PRESS_W-1:0]       in_pressure = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [TEMP_W-1:0] out_temperature;
  logic                     out_in_range;

  temp_scoreboard sb = new();

  int  cycles = 0;
  int  send_max = 0;
  int  stall_max = 0;
  bit  long_hold_req = 1'b0;
  int  input_stall_cycles = 0;

  refrigerant_pressure_to_temp_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pressure     (in_pressure),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_temperature (out_temperature),
    .out_in_range    (out_in_range)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall) input_stall_cycles <= input_stall_cycles + 1;
    if (rst_n && in_valid && !in_stall) sb.note_pressure(in_pressure);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_temperature, out_in_range);
  end

  // result side: per item stall draw, plus one long hold-off on request
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      n = $urandom_range(0, stall_max);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(logic [PRESS_W-1:0] p, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_pressure <= p;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [PRESS_W-1:0] pick_pressure();
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(0, N_BP - 1);
    if (sel < 65) return PRESS_W'($urandom_range(PRESS_TAB[0], PRESS_TAB[N_BP-1] - 1));
    if (sel < 75) return PRESS_W'(PRESS_TAB[k]);
    if (sel < 80) return PRESS_W'(PRESS_TAB[k] + ($urandom_range(0, 1) ? 1 : -1));
    return PRESS_W'($urandom_range(0, (1 << PRESS_W) - 1));
  endfunction

  initial begin
    int directed [] = '{0, 8191, 171, 172, 173, 194, 195, 196, 711, 712, 713,
                        4984, 4985, 4986, 5000, 4776, 2730, 5461, 4095, 4096,
                        1, 1500, 3333};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    stall_max = 0;
    send_max  = 0;
    foreach (directed[i]) send_item(PRESS_W'(directed[i]), $urandom_range(0, send_max));

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 200 == 0) begin
        case ((k / 200) % 4)
          0: begin send_max = 0;  stall_max = 0;  end
          1: begin send_max = 12; stall_max = 12; end
          2: begin send_max = 12; stall_max = 0;  end
          default: begin send_max = 0; stall_max = 12; end
        endcase
      end
      if (k == 700) long_hold_req = 1'b1;
      send_item(pick_pressure(), $urandom_range(0, send_max));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("checked %0d temperature results, %0d of them outside the table span",
             sb.checked, sb.out_of_span);
    $display("input held back for %0d cycles under result-side pressure",
             input_stall_cycles);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
